[rtl/srot_pkg.sv]
// Package for the sorted range owner table: entry and result types,
// operation and status codes, and field widths. No dependencies.
package srot_pkg;

  localparam int ADDR_W  = 48;
  localparam int OWNER_W = 9;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_WITHDRAW = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic [OWNER_W-1:0] found_owner;
    logic [1:0]         status;
  } result_t;

endpackage

[rtl/srot_req_if.sv]
// Request channel of the sorted range owner table.
// Depends on srot_pkg for field widths.
interface srot_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [srot_pkg::OWNER_W-1:0] owner_id;
  logic [srot_pkg::ADDR_W-1:0]       address;

  modport source (output valid, func, owner_id, address, input ready);
  modport sink (input valid, func, owner_id, address, output ready);
endinterface

[rtl/srot_rsp_if.sv]
// Response channel of the sorted range owner table.
// Depends on srot_pkg for field widths.
interface srot_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [srot_pkg::OWNER_W-1:0] found_owner;
  logic [1:0]                        status;

  modport source (output valid, found_owner, status, input ready);
  modport sink (input valid, found_owner, status, output ready);
endinterface

[rtl/srot_ram.sv]
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on srot_pkg for the entry type.
module srot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  srot_pkg::entry_t       wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output srot_pkg::entry_t       rd_data
);

  srot_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/srot_seq.sv]
// Sequencer of the sorted range owner table: insertion shift, withdraw
// compaction and binary search over the entry memory. Uses srot_pkg,
// srot_req_if and srot_ram.
module srot_seq #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  srot_req_if.sink         req,
  output logic             res_valid,
  input  logic             res_ready,
  output srot_pkg::result_t res
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS     = 7'b0000010,
    S_INS_PUT = 7'b0000100,
    S_WD      = 7'b0001000,
    S_LK      = 7'b0010000,
    S_LK_OWN  = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic found, found_next;
  srot_pkg::result_t res_next;
  logic [srot_pkg::OWNER_W-1:0] owner;
  logic [srot_pkg::ADDR_W-1:0] addr;

  logic ram_wr_en, ram_rd_en;
  logic [IW-1:0] ram_wr_addr, ram_rd_addr;
  srot_pkg::entry_t ram_wr_data, ram_rd_data;

  logic [CW:0] mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] ptr_dec, ptr_inc;
  logic match;

  srot_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign ptr_dec   = ptr - ONE_C;
  assign ptr_inc   = ptr + ONE_C;
  assign match     = (ram_rd_data.owner == owner);

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    lo_next     = lo;
    hi_next     = hi;
    found_next  = found;
    res_next    = res;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr[IW-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr[IW-1:0];
    mid_sum     = {1'b0, lo} + {1'b0, hi};
    mid         = mid_sum[CW:1];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next.found_owner = '0;
          res_next.status      = srot_pkg::ST_OK;
          found_next           = 1'b0;
          case (req.func)
            srot_pkg::OP_INSERT: begin
              if (count == DEPTH_C) begin
                res_next.status = srot_pkg::ST_FULL;
                state_next      = S_RESP;
              end else if (count == '0) begin
                ptr_next   = '0;
                state_next = S_INS_PUT;
              end else begin
                ptr_next    = count;
                ram_rd_en   = 1'b1;
                ram_rd_addr = IW'(count - ONE_C);
                state_next  = S_INS;
              end
            end
            srot_pkg::OP_WITHDRAW: begin
              if (count == '0) begin
                res_next.status = srot_pkg::ST_NOT_FOUND;
                state_next      = S_RESP;
              end else begin
                ptr_next    = '0;
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_next  = S_WD;
              end
            end
            srot_pkg::OP_LOOKUP: begin
              if (count == '0) begin
                res_next.status = srot_pkg::ST_EMPTY;
                state_next      = S_RESP;
              end else begin
                lo_next = '0;
                hi_next = count;
                mid_sum = {1'b0, count};
                mid     = mid_sum[CW:1];
                if (count == ONE_C) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_next  = S_LK_OWN;
                end else begin
                  ptr_next    = mid;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = mid[IW-1:0];
                  state_next  = S_LK;
                end
              end
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_INS: begin
        if (addr > ram_rd_data.base) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ptr[IW-1:0];
          ram_wr_data = ram_rd_data;
          ptr_next    = ptr_dec;
          if (ptr_dec == '0) begin
            state_next = S_INS_PUT;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = IW'(ptr_dec - ONE_C);
          end
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_wr_en        = 1'b1;
        ram_wr_addr      = ptr[IW-1:0];
        ram_wr_data.base = addr;
        ram_wr_data.owner = owner;
        count_next       = count + ONE_C;
        state_next       = S_RESP;
      end
      S_WD: begin
        if (found) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = IW'(ptr_dec);
          ram_wr_data = ram_rd_data;
        end else if (match) begin
          found_next = 1'b1;
        end
        if (ptr_inc < count) begin
          ptr_next    = ptr_inc;
          ram_rd_en   = 1'b1;
          ram_rd_addr = IW'(ptr_inc);
        end else begin
          if (found || match) begin
            count_next = count - ONE_C;
          end else begin
            res_next.status = srot_pkg::ST_NOT_FOUND;
          end
          state_next = S_RESP;
        end
      end
      S_LK: begin
        if (ram_rd_data.base > addr) begin
          lo_next = ptr;
        end else begin
          hi_next = ptr;
        end
        mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
        mid     = mid_sum[CW:1];
        ram_rd_en = 1'b1;
        if ((hi_next - lo_next) > ONE_C) begin
          ptr_next    = mid;
          ram_rd_addr = mid[IW-1:0];
        end else begin
          ram_rd_addr = lo_next[IW-1:0];
          state_next  = S_LK_OWN;
        end
      end
      S_LK_OWN: begin
        res_next.found_owner = ram_rd_data.owner;
        state_next           = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    lo    <= lo_next;
    hi    <= hi_next;
    found <= found_next;
    res   <= res_next;
    if (req.valid && req.ready) begin
      owner <= req.owner_id;
      addr  <= req.address;
    end
  end

endmodule

[rtl/sorted_range_owner_table_unit.sv]
// The unit keeps up to TABLE_DEPTH (base, owner) entries sorted by descending base in one
// synchronous memory and handles one request at a time. The memory is read at most once per
// cycle, so an insert reads each entry that it compares for the shift, a withdraw reads every
// stored entry, and a lookup reads one entry per binary search step and then the owner entry.
// A finished response sits in an output register, and the next request is taken while it waits.
module sorted_range_owner_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  srot_req_if.sink req,
  srot_rsp_if.source rsp
);

  logic              res_valid;
  logic              res_ready;
  srot_pkg::result_t res;
  logic              out_valid;
  srot_pkg::result_t out_res;

  srot_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready       = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.found_owner = $signed(out_res.found_owner);
  assign rsp.status      = out_res.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

[sim/srot_table_checker.sv]
// Checker for the sorted range owner table: watches the request and response
// channels, predicts each response from its own copy of the table and compares.
// Depends on srot_pkg and the srot_req_if and srot_rsp_if interfaces.
module srot_table_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  srot_req_if        req,
  srot_rsp_if        rsp,
  output int         n_fail,
  output int         n_pending,
  output int         n_responses,
  output int         n_full,
  output int         n_missing,
  output int         n_empty,
  output int         n_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [srot_pkg::ADDR_W-1:0]  tbl_base  [TABLE_DEPTH];
  logic [srot_pkg::OWNER_W-1:0] tbl_owner [TABLE_DEPTH];
  int unsigned                  tbl_count;

  srot_pkg::result_t owed_responses[$];
  int      fail_tally;
  int      response_tally;
  int      full_tally;
  int      missing_tally;
  int      empty_tally;
  int      hit_tally;

  function automatic srot_pkg::result_t predict_table_op(
      input logic [1:0] func,
      input logic [srot_pkg::OWNER_W-1:0] owner,
      input logic [srot_pkg::ADDR_W-1:0] addr);
    srot_pkg::result_t res;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic        matched;
    res.found_owner = '0;
    res.status = srot_pkg::ST_OK;
    matched = 1'b0;
    case (func)
      srot_pkg::OP_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = srot_pkg::ST_FULL;
        end else begin
          pos = tbl_count;
          while (pos > 0 && addr > tbl_base[pos-1]) begin
            tbl_base[pos] = tbl_base[pos-1];
            tbl_owner[pos] = tbl_owner[pos-1];
            pos--;
          end
          tbl_base[pos] = addr;
          tbl_owner[pos] = owner;
          tbl_count++;
        end
      end
      srot_pkg::OP_WITHDRAW: begin
        for (pos = 0; pos < tbl_count && !matched; pos++) begin
          if (tbl_owner[pos] == owner) begin
            matched = 1'b1;
            for (int unsigned k = pos; k + 1 < tbl_count; k++) begin
              tbl_base[k] = tbl_base[k+1];
              tbl_owner[k] = tbl_owner[k+1];
            end
          end
        end
        if (matched) begin
          tbl_count--;
        end else begin
          res.status = srot_pkg::ST_NOT_FOUND;
        end
      end
      srot_pkg::OP_LOOKUP: begin
        if (tbl_count == 0) begin
          res.status = srot_pkg::ST_EMPTY;
        end else begin
          lo = 0;
          hi = tbl_count;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (tbl_base[mid] > addr) begin
              lo = mid;
            end else begin
              hi = mid;
            end
          end
          res.found_owner = tbl_owner[lo];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_tally++;
    if (fail_tally <= 20) begin
      $display("%0t ns: mismatch in %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    srot_pkg::result_t owed;
    srot_pkg::result_t fresh;
    if (rst) begin
      owed_responses.delete();
      tbl_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        response_tally++;
        if (owed_responses.size() == 0) begin
          report_mismatch("response with no request waiting",
                          16'({rsp.found_owner, rsp.status}), '0);
        end else begin
          owed = owed_responses.pop_front();
          if (rsp.found_owner !== owed.found_owner) begin
            report_mismatch("found_owner", 16'({rsp.found_owner}),
                            16'(owed.found_owner));
          end
          if (rsp.status !== owed.status) begin
            report_mismatch("status code", 16'(rsp.status), 16'(owed.status));
          end
        end
      end
      if (req.valid && req.ready) begin
        fresh = predict_table_op(req.func, req.owner_id, req.address);
        case (fresh.status)
          srot_pkg::ST_FULL:      full_tally++;
          srot_pkg::ST_NOT_FOUND: missing_tally++;
          srot_pkg::ST_EMPTY:     empty_tally++;
          default: begin
            if (req.func == srot_pkg::OP_LOOKUP) begin
              hit_tally++;
            end
          end
        endcase
        owed_responses.push_back(fresh);
      end
    end
    n_fail <= fail_tally;
    n_pending <= owed_responses.size();
    n_responses <= response_tally;
    n_full <= full_tally;
    n_missing <= missing_tally;
    n_empty <= empty_tally;
    n_hits <= hit_tally;
  end

endmodule

[sim/tb_sorted_range_owner_table_unit.sv]
// Testbench top for sorted_range_owner_table_unit: clock, reset, request and
// response traffic under several idle patterns, and the verdict.
// Depends on srot_pkg, both channel interfaces, the unit and srot_table_checker.
module tb_sorted_range_owner_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               DEPTH        = 16;
  localparam int               PHASE_ITEMS  = 410;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam logic [1:0]       OP_UNUSED    = 2'd3;
  localparam logic [srot_pkg::OWNER_W-1:0] MAIN_OWNER = '1;

  logic clk = 1'b0;
  logic rst;
  logic rx_hold;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   n_sent;
  int   cycle_count;

  int n_fail;
  int n_pending;
  int n_responses;
  int n_full;
  int n_missing;
  int n_empty;
  int n_hits;

  srot_req_if req_ch ();
  srot_rsp_if rsp_ch ();

  sorted_range_owner_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  srot_table_checker #(
    .TABLE_DEPTH(DEPTH)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .n_fail(n_fail),
    .n_pending(n_pending),
    .n_responses(n_responses),
    .n_full(n_full),
    .n_missing(n_missing),
    .n_empty(n_empty),
    .n_hits(n_hits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses outstanding", cycle_count,
               n_pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready = !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [srot_pkg::ADDR_W-1:0] pick_address();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return srot_pkg::ADDR_W'($urandom_range(0, 7)) << 12;
      4, 5:    return srot_pkg::ADDR_W'($urandom_range(0, 255));
      default: return wide[srot_pkg::ADDR_W-1:0];
    endcase
  endfunction

  function automatic logic [srot_pkg::OWNER_W-1:0] pick_owner();
    int unsigned k;
    if ($urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, 6);
      return (k == 6) ? MAIN_OWNER : srot_pkg::OWNER_W'(k);
    end else if ($urandom_range(0, 19) == 0) begin
      return MAIN_OWNER;
    end
    return srot_pkg::OWNER_W'($urandom_range(0, 255));
  endfunction

  task automatic send_request(input logic [1:0] f,
                              input logic [srot_pkg::OWNER_W-1:0] owner,
                              input logic [srot_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.func = f;
    req_ch.owner_id = owner;
    req_ch.address = addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // Windows alternate between filling and draining the table so that both
  // the full and the empty states are reached repeatedly.
  task automatic send_random_request();
    logic [1:0]  f;
    int unsigned roll;
    logic        drain;
    drain = ((n_sent / 32) % 2) == 1;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      f = OP_UNUSED;
    end else if (roll < 35) begin
      f = srot_pkg::OP_LOOKUP;
    end else if (drain) begin
      f = (roll < 88) ? srot_pkg::OP_WITHDRAW : srot_pkg::OP_INSERT;
    end else begin
      f = (roll < 92) ? srot_pkg::OP_INSERT : srot_pkg::OP_WITHDRAW;
    end
    send_request(f, pick_owner(), pick_address());
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.func = srot_pkg::OP_INSERT;
    req_ch.owner_id = '0;
    req_ch.address = '0;
    rst = 1'b1;
    rx_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(srot_pkg::OP_LOOKUP, '0, 48'h1234);
    send_request(srot_pkg::OP_WITHDRAW, srot_pkg::OWNER_W'(9), '0);
    send_request(OP_UNUSED, MAIN_OWNER, '1);
    send_request(srot_pkg::OP_INSERT, MAIN_OWNER, '1);
    send_request(srot_pkg::OP_INSERT, srot_pkg::OWNER_W'(255), '0);
    send_request(srot_pkg::OP_INSERT, srot_pkg::OWNER_W'(1), 48'h1000);
    send_request(srot_pkg::OP_INSERT, srot_pkg::OWNER_W'(2), 48'h1000);
    send_request(srot_pkg::OP_LOOKUP, '0, '0);
    send_request(srot_pkg::OP_LOOKUP, '0, '1);
    send_request(srot_pkg::OP_LOOKUP, '0, 48'h0fff);
    send_request(srot_pkg::OP_WITHDRAW, srot_pkg::OWNER_W'(2), '0);
    send_request(srot_pkg::OP_WITHDRAW, MAIN_OWNER, '0);
    for (int k = 0; k < 14; k++) begin
      send_request(srot_pkg::OP_INSERT, srot_pkg::OWNER_W'(10 + k), pick_address());
    end
    send_request(srot_pkg::OP_INSERT, srot_pkg::OWNER_W'(99), 48'h5000);
    send_request(srot_pkg::OP_LOOKUP, '0, 48'h1000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (PHASE_ITEMS) send_random_request();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        repeat (60) send_random_request();
      end
    join
    req_ch.valid = 1'b0;

    while (n_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests and checked %0d responses, over four idle patterns and a",
             n_sent, n_responses);
    $display("long receiver hold: %0d full-table, %0d missing-owner, %0d empty, %0d hits.",
             n_full, n_missing, n_empty, n_hits);
    if (n_fail == 0 && n_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/srot_pkg.sv
rtl/srot_req_if.sv
rtl/srot_rsp_if.sv
rtl/srot_ram.sv
rtl/srot_seq.sv
rtl/sorted_range_owner_table_unit.sv
sim/srot_table_checker.sv
sim/tb_sorted_range_owner_table_unit.sv
